### src/tmrf_pkg.sv
// shared types, constants and helpers for the tile map rectangle fill store
`default_nettype none

package tmrf_pkg;

  // map geometry
  localparam int MAP_SIDE   = 128;
  localparam int TILE_BITS  = 8;
  localparam int POS_W      = $clog2(MAP_SIDE);
  localparam int ADDR_W     = 2 * POS_W;
  localparam int CELLS      = MAP_SIDE * MAP_SIDE;
  localparam int BRUSH_W    = 8;

  // configuration register widths
  localparam int ATLAS_W    = 5;
  localparam int TEX_W      = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // divider and product widths
  localparam int DIV_W      = TEX_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int PROD_W     = 8 + TEX_W;
  localparam int PIX_W      = 20;

  // initial map pattern
  localparam int INIT_FILL    = 3;
  localparam int CORNER_SIDE  = 10;
  localparam int CORNER_CODE  = 0;
  localparam int BLOCK_LO     = 5;
  localparam int BLOCK_HI     = 7;
  localparam int BLOCK_CODE   = 1;
  localparam int STRIPE_COL   = 2;
  localparam int STRIPE_CODE  = 2;

  typedef enum logic [1:0] {
    MODE_FILL  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATLAS_COLS = 2'd0,
    CFG_ATLAS_ROWS = 2'd1,
    CFG_TEX_WIDTH  = 2'd2,
    CFG_TEX_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_READ_DATA,
    ST_DIV_CODE,
    ST_DIV_WIDTH,
    ST_DIV_HEIGHT,
    ST_MUL_U,
    ST_MUL_V,
    ST_DONE
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [BRUSH_W-1:0] brush_width;
    logic [BRUSH_W-1:0] brush_height;
    logic [7:0]         tile_value;
  } in_t;

  typedef struct packed {
    logic [7:0]       tile_code;
    logic [7:0]       atlas_column;
    logic [7:0]       atlas_row;
    logic [PIX_W-1:0] u_pixel;
    logic [PIX_W-1:0] v_pixel;
  } out_t;

  // power-up tile code of one map cell
  function automatic logic [TILE_BITS-1:0] init_tile(input logic [POS_W-1:0] row,
                                                     input logic [POS_W-1:0] col);
    logic [TILE_BITS-1:0] code;
    code = TILE_BITS'(INIT_FILL);
    if (int'(row) < CORNER_SIDE && int'(col) < CORNER_SIDE) begin
      code = TILE_BITS'(CORNER_CODE);
    end
    if (int'(row) >= BLOCK_LO && int'(row) <= BLOCK_HI &&
        int'(col) >= BLOCK_LO && int'(col) <= BLOCK_HI) begin
      code = TILE_BITS'(BLOCK_CODE);
    end
    if (int'(row) < CORNER_SIDE && int'(col) == STRIPE_COL) begin
      code = TILE_BITS'(STRIPE_CODE);
    end
    return code;
  endfunction

endpackage

`default_nettype wire

### src/tile_map_rect_fill_store_unit.sv
// tile map store with rectangle fill, single tile write/read and atlas lookup
// sequence: a no-op goes straight to the result; write, read and fill run the
//   divider after their memory access; a stalled result holds the next one until taken
// requests: one at a time, the next taken once the result shows; each request but
//   a no-op runs the 13-step divider three times
// reset: control clears at once, then a clearing pass loads the initial pattern
//   into all 16384 cells before the first request is taken; config resets to 1
`default_nettype none

module tile_map_rect_fill_store_unit import tmrf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // requests
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire in_t                   in_req_i,
  // results
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      out_t                  out_rsp_o
);

  // configuration registers
  logic [ATLAS_W-1:0] atlas_cols_q, atlas_rows_q;
  logic [TEX_W-1:0]   tex_width_q, tex_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_cols_q <= ATLAS_W'(1);
      atlas_rows_q <= ATLAS_W'(1);
      tex_width_q  <= TEX_W'(1);
      tex_height_q <= TEX_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ATLAS_COLS: atlas_cols_q <= cfg_data_i[ATLAS_W-1:0];
        CFG_ATLAS_ROWS: atlas_rows_q <= cfg_data_i[ATLAS_W-1:0];
        CFG_TEX_WIDTH:  tex_width_q  <= cfg_data_i[TEX_W-1:0];
        CFG_TEX_HEIGHT: tex_height_q <= cfg_data_i[TEX_W-1:0];
        default: ;
      endcase
    end
  end

  // zero registers act as one
  logic [ATLAS_W-1:0] cols_eff, rows_eff;
  logic [TEX_W-1:0]   tex_w_eff, tex_h_eff;
  assign cols_eff  = (atlas_cols_q == '0) ? ATLAS_W'(1) : atlas_cols_q;
  assign rows_eff  = (atlas_rows_q == '0) ? ATLAS_W'(1) : atlas_rows_q;
  assign tex_w_eff = (tex_width_q == '0)  ? TEX_W'(1)   : tex_width_q;
  assign tex_h_eff = (tex_height_q == '0) ? TEX_W'(1)   : tex_height_q;

  // state and request registers
  state_e                 state_q, state_d;
  logic [ADDR_W-1:0]      clr_cnt_q;
  logic [POS_W-1:0]       px_q, py_q;
  logic [POS_W-1:0]       fill_row_q, fill_col_q, fill_last_col_q;
  logic [TILE_BITS-1:0]   code_q;
  logic                   nop_q;
  logic                   out_valid_q;
  out_t                   out_q;

  // memory ports
  logic [TILE_BITS-1:0]   tile_mem [CELLS];
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [TILE_BITS-1:0]   mem_wdata;
  logic [TILE_BITS-1:0]   rd_data_q;

  // shared divider
  logic [DIV_W-1:0]       quo_q, quo_n;
  logic [ATLAS_W-1:0]     rem_q, rem_n;
  logic [DIV_CNT_W-1:0]   div_cnt_q;
  logic [ATLAS_W:0]       div_trial;
  logic [ATLAS_W-1:0]     div_divisor;
  logic                   div_ge, div_run, div_last, div_load;
  logic [DIV_W-1:0]       div_dividend;

  // division and product results
  logic [ATLAS_W-1:0]     atlas_col_q;
  logic [7:0]             atlas_row_q;
  logic [TEX_W-1:0]       sw_q, sh_q;
  logic [PIX_W-1:0]       u_q, v_q;

  // request decode
  logic                   in_accept;
  logic                   on_map;
  logic [2*ATLAS_W-1:0]   tiles_m1;
  logic [TILE_BITS-1:0]   fill_code;
  logic [BRUSH_W-1:0]     bw_eff, bh_eff;
  logic [POS_W+BRUSH_W-1:0] end_x;
  logic [POS_W-1:0]       last_col;
  logic [POS_W:0]         py_plus1;
  logic [POS_W-1:0]       top_row;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign on_map = ((POS_W+1)'(in_req_i.pos_x) < (POS_W+1)'(MAP_SIDE)) &&
                  ((POS_W+1)'(in_req_i.pos_y) < (POS_W+1)'(MAP_SIDE));

  // fill code clamp to the atlas tile count
  always_comb begin
    tiles_m1 = (2*ATLAS_W)'(cols_eff) * (2*ATLAS_W)'(rows_eff) - (2*ATLAS_W)'(1);
    if ((2*ATLAS_W)'(in_req_i.tile_value) > tiles_m1) begin
      fill_code = tiles_m1[TILE_BITS-1:0];
    end else begin
      fill_code = in_req_i.tile_value;
    end
  end

  // brush clamp and rectangle bounds
  always_comb begin
    bw_eff = in_req_i.brush_width;
    if (bw_eff == '0) bw_eff = BRUSH_W'(1);
    if (int'(bw_eff) > MAP_SIDE) bw_eff = BRUSH_W'(MAP_SIDE);
    bh_eff = in_req_i.brush_height;
    if (bh_eff == '0) bh_eff = BRUSH_W'(1);
    if (int'(bh_eff) > MAP_SIDE) bh_eff = BRUSH_W'(MAP_SIDE);
    end_x = (POS_W+BRUSH_W)'(in_req_i.pos_x) + (POS_W+BRUSH_W)'(bw_eff);
    if (end_x > (POS_W+BRUSH_W)'(MAP_SIDE)) end_x = (POS_W+BRUSH_W)'(MAP_SIDE);
    last_col = POS_W'(end_x - (POS_W+BRUSH_W)'(1));
    py_plus1 = (POS_W+1)'(in_req_i.pos_y) + (POS_W+1)'(1);
    if ((BRUSH_W+1)'(py_plus1) > (BRUSH_W+1)'(bh_eff)) begin
      top_row = POS_W'((BRUSH_W+1)'(py_plus1) - (BRUSH_W+1)'(bh_eff));
    end else begin
      top_row = '0;
    end
  end

  // divider step: restoring, one quotient bit a cycle
  assign div_run     = (state_q == ST_DIV_CODE) || (state_q == ST_DIV_WIDTH) ||
                       (state_q == ST_DIV_HEIGHT);
  assign div_last    = div_run && (div_cnt_q == DIV_CNT_W'(DIV_W - 1));
  assign div_divisor = (state_q == ST_DIV_HEIGHT) ? rows_eff : cols_eff;
  assign div_trial   = {rem_q, quo_q[DIV_W-1]};
  assign div_ge      = div_trial >= {1'b0, div_divisor};
  assign rem_n       = div_ge ? ATLAS_W'(div_trial - {1'b0, div_divisor})
                              : div_trial[ATLAS_W-1:0];
  assign quo_n       = {quo_q[DIV_W-2:0], div_ge};

  // shared multiplier with saturation
  logic [7:0]        mul_a;
  logic [TEX_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PIX_W-1:0]  mul_sat;
  assign mul_a   = (state_q == ST_MUL_U) ? 8'(atlas_col_q) : atlas_row_q;
  assign mul_b   = (state_q == ST_MUL_U) ? sw_q : sh_q;
  assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign mul_sat = (mul_p > PROD_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : mul_p[PIX_W-1:0];

  // sequencer: next state, memory write and divider load
  always_comb begin
    state_d      = state_q;
    mem_we       = 1'b0;
    mem_waddr    = {fill_row_q, fill_col_q};
    mem_wdata    = code_q;
    div_load     = 1'b0;
    div_dividend = DIV_W'(code_q);
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = init_tile(clr_cnt_q[ADDR_W-1:POS_W], clr_cnt_q[POS_W-1:0]);
        if (clr_cnt_q == ADDR_W'(CELLS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_req_i.mode)
            MODE_FILL: begin
              if (on_map) begin
                state_d = ST_FILL;
              end else begin
                state_d      = ST_DIV_CODE;
                div_load     = 1'b1;
                div_dividend = DIV_W'(fill_code);
              end
            end
            MODE_READ: state_d = ST_READ;
            MODE_WRITE: begin
              mem_we       = on_map;
              mem_waddr    = {in_req_i.pos_y, in_req_i.pos_x};
              mem_wdata    = in_req_i.tile_value[TILE_BITS-1:0];
              state_d      = ST_DIV_CODE;
              div_load     = 1'b1;
              div_dividend = DIV_W'(in_req_i.tile_value[TILE_BITS-1:0]);
            end
            MODE_NOP: state_d = ST_DONE;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (fill_col_q == fill_last_col_q && fill_row_q == py_q) begin
          state_d  = ST_DIV_CODE;
          div_load = 1'b1;
        end
      end
      ST_READ: state_d = ST_READ_DATA;
      ST_READ_DATA: begin
        state_d      = ST_DIV_CODE;
        div_load     = 1'b1;
        div_dividend = DIV_W'(rd_data_q);
      end
      ST_DIV_CODE: begin
        if (div_last) begin
          state_d      = ST_DIV_WIDTH;
          div_load     = 1'b1;
          div_dividend = tex_w_eff;
        end
      end
      ST_DIV_WIDTH: begin
        if (div_last) begin
          state_d      = ST_DIV_HEIGHT;
          div_load     = 1'b1;
          div_dividend = tex_h_eff;
        end
      end
      ST_DIV_HEIGHT: begin
        if (div_last) state_d = ST_MUL_U;
      end
      ST_MUL_U: state_d = ST_MUL_V;
      ST_MUL_V: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register and control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR && state_d == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (div_load) begin
        div_cnt_q <= '0;
      end else if (div_run) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // tile memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) tile_mem[mem_waddr] <= mem_wdata;
    rd_data_q <= tile_mem[{py_q, px_q}];
  end

  // request capture and fill walk
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      px_q            <= in_req_i.pos_x;
      py_q            <= in_req_i.pos_y;
      fill_row_q      <= top_row;
      fill_col_q      <= in_req_i.pos_x;
      fill_last_col_q <= last_col;
      nop_q           <= (in_req_i.mode == MODE_NOP);
      unique case (in_req_i.mode)
        MODE_FILL:  code_q <= fill_code;
        MODE_WRITE: code_q <= in_req_i.tile_value[TILE_BITS-1:0];
        MODE_READ:  code_q <= '0;
        MODE_NOP:   code_q <= '0;
        default:    code_q <= '0;
      endcase
    end else if (state_q == ST_FILL) begin
      if (fill_col_q == fill_last_col_q) begin
        fill_col_q <= px_q;
        fill_row_q <= fill_row_q + POS_W'(1);
      end else begin
        fill_col_q <= fill_col_q + POS_W'(1);
      end
    end else if (state_q == ST_READ_DATA) begin
      code_q <= rd_data_q;
    end
  end

  // divider datapath and result capture
  always_ff @(posedge clk_i) begin
    if (div_load) begin
      quo_q <= div_dividend;
      rem_q <= '0;
    end else if (div_run) begin
      quo_q <= quo_n;
      rem_q <= rem_n;
    end
    if (div_last) begin
      unique case (state_q)
        ST_DIV_CODE: begin
          atlas_col_q <= rem_n;
          atlas_row_q <= quo_n[7:0];
        end
        ST_DIV_WIDTH:  sw_q <= quo_n;
        ST_DIV_HEIGHT: sh_q <= quo_n;
        default: ;
      endcase
    end
    if (state_q == ST_MUL_U) u_q <= mul_sat;
    if (state_q == ST_MUL_V) v_q <= mul_sat;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      if (nop_q) begin
        out_q <= '0;
      end else begin
        out_q.tile_code    <= 8'(code_q);
        out_q.atlas_column <= 8'(atlas_col_q);
        out_q.atlas_row    <= atlas_row_q;
        out_q.u_pixel      <= u_q;
        out_q.v_pixel      <= v_q;
      end
    end
  end

endmodule

`default_nettype wire
